@@ src/key_press_event_detector_core_assert.svh @@
// assertion macros for the key press event detector
// expects signals named clock and reset in the module that uses them
`ifndef KEY_PRESS_EVENT_DETECTOR_CORE_ASSERT_SVH
`define KEY_PRESS_EVENT_DETECTOR_CORE_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define KPED_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kped assertion failed");

// consequent holds in the cycle after the antecedent
`define KPED_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kped assertion failed");

`endif

@@ src/kped_pkg.sv @@
// shared types and constants of the key press event detector
// no dependencies
package kped_pkg;

   // command codes
   localparam logic [1:0] CMD_SAMPLE     = 2'd0;
   localparam logic [1:0] CMD_FORCE_HIGH = 2'd1;
   localparam logic [1:0] CMD_FORCE_LOW  = 2'd2;

   // detector modes
   localparam logic [1:0] MODE_EDGE    = 2'd0;
   localparam logic [1:0] MODE_DOUBLE  = 2'd1;
   localparam logic [1:0] MODE_REPEAT  = 2'd2;
   localparam logic [1:0] MODE_RELEASE = 2'd3;

   // event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_PRESS   = 2'd1;
   localparam logic [1:0] EV_REPEAT  = 2'd2;
   localparam logic [1:0] EV_HOLDING = 2'd3;

   // register indexes
   localparam logic [1:0] REG_MODE          = 2'd0;
   localparam logic [1:0] REG_HOLD_DELAY    = 2'd1;
   localparam logic [1:0] REG_REPEAT_PERIOD = 2'd2;
   localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd3;

   localparam int         CSR_ADDR_W = 4;
   localparam int         CSR_DATA_W = 32;

   // reset values
   localparam logic [1:0] MODE_RST          = MODE_EDGE;
   localparam logic [7:0] HOLD_DELAY_RST    = 8'd10;
   localparam logic [7:0] REPEAT_PERIOD_RST = 8'd2;
   localparam logic [7:0] DOUBLE_WINDOW_RST = 8'd5;

   localparam logic [7:0] ELAPSED_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] hold_delay;
      logic [7:0] repeat_period;
      logic [7:0] double_window;
   } cfg_type;

   typedef struct packed {
      logic       prev_level;
      logic       repeating;
      logic       long_hold;
      logic       first_press_seen;
      logic [7:0] elapsed;
   } state_type;

endpackage

@@ src/kped_csr.sv @@
// configuration registers of the key press event detector, apb-style access
// depends on kped_pkg
module kped_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kped_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [kped_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [kped_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output kped_pkg::cfg_type               cfg
);

   kped_pkg::cfg_type cfg_ff;
   kped_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            kped_pkg::REG_MODE:          cfg_in.mode          = pwdata[1:0];
            kped_pkg::REG_HOLD_DELAY:    cfg_in.hold_delay    = pwdata[7:0];
            kped_pkg::REG_REPEAT_PERIOD: cfg_in.repeat_period = pwdata[7:0];
            kped_pkg::REG_DOUBLE_WINDOW: cfg_in.double_window = pwdata[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         kped_pkg::REG_MODE:          prdata = {30'd0, cfg_ff.mode};
         kped_pkg::REG_HOLD_DELAY:    prdata = {24'd0, cfg_ff.hold_delay};
         kped_pkg::REG_REPEAT_PERIOD: prdata = {24'd0, cfg_ff.repeat_period};
         kped_pkg::REG_DOUBLE_WINDOW: prdata = {24'd0, cfg_ff.double_window};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= kped_pkg::MODE_RST;
         cfg_ff.hold_delay    <= kped_pkg::HOLD_DELAY_RST;
         cfg_ff.repeat_period <= kped_pkg::REPEAT_PERIOD_RST;
         cfg_ff.double_window <= kped_pkg::DOUBLE_WINDOW_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/kped_detect.sv @@
// detector state and the per-sample event logic for all four modes
// depends on kped_pkg and key_press_event_detector_core_assert.svh
`include "key_press_event_detector_core_assert.svh"

module kped_detect (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          cmd,
   input  logic                key_level,
   input  logic                tick,
   input  kped_pkg::cfg_type   cfg,
   output logic [1:0]          event_res,
   output kped_pkg::state_type state
);

   kped_pkg::state_type state_ff;
   kped_pkg::state_type state_in;
   kped_pkg::state_type nx;
   logic [1:0]          ev;

   assign state     = state_ff;
   assign event_res = ev;

   always_comb begin
      logic       k;
      logic       c;
      logic       in_window;
      logic       done;
      nx        = state_ff;
      ev        = kped_pkg::EV_NONE;
      k         = key_level;
      c         = 1'b0;
      in_window = 1'b0;
      done      = 1'b0;

      // saturating decisecond count, advanced on every transfer that carries a tick
      if (tick && (nx.elapsed != kped_pkg::ELAPSED_MAX)) begin
         nx.elapsed = nx.elapsed + 8'd1;
      end

      case (cmd)
         kped_pkg::CMD_FORCE_HIGH: nx.prev_level = 1'b1;
         kped_pkg::CMD_FORCE_LOW:  nx.prev_level = 1'b0;
         kped_pkg::CMD_SAMPLE: begin
            case (cfg.mode)
               kped_pkg::MODE_EDGE: begin
                  if (!nx.prev_level && k) begin
                     ev = kped_pkg::EV_PRESS;
                  end
                  nx.prev_level = k;
               end
               kped_pkg::MODE_DOUBLE: begin
                  c             = !nx.prev_level && k;
                  nx.prev_level = k;
                  if (!nx.first_press_seen && c) begin
                     nx.first_press_seen = 1'b1;
                     nx.elapsed          = 8'd0;
                  end else begin
                     in_window = nx.elapsed <= cfg.double_window;
                     if (nx.first_press_seen && in_window && c) begin
                        nx.first_press_seen = 1'b0;
                        ev                  = kped_pkg::EV_PRESS;
                     end else if (!in_window) begin
                        nx.first_press_seen = 1'b0;
                     end
                  end
               end
               kped_pkg::MODE_REPEAT: begin
                  if (!nx.prev_level && k) begin
                     nx.prev_level = 1'b1;
                     nx.elapsed    = 8'd0;
                     ev            = kped_pkg::EV_PRESS;
                  end else begin
                     nx.prev_level = k;
                     if (k) begin
                        if (!nx.repeating && (nx.elapsed >= cfg.hold_delay)) begin
                           nx.repeating = 1'b1;
                           nx.elapsed   = 8'd0;
                        end
                        if (nx.repeating && (nx.elapsed >= cfg.repeat_period)) begin
                           nx.elapsed = 8'd0;
                           ev         = kped_pkg::EV_REPEAT;
                        end
                     end else begin
                        nx.repeating = 1'b0;
                     end
                  end
               end
               kped_pkg::MODE_RELEASE: begin
                  // release after a long hold gives no press
                  if (nx.long_hold && nx.prev_level && !k) begin
                     nx.long_hold  = 1'b0;
                     nx.prev_level = 1'b0;
                  end
                  if (!nx.prev_level && k) begin
                     nx.elapsed = 8'd0;
                  end
                  if (!nx.long_hold && nx.prev_level && !k) begin
                     nx.prev_level = 1'b0;
                     nx.elapsed    = 8'd0;
                     ev            = kped_pkg::EV_PRESS;
                  end else begin
                     if (nx.prev_level && k) begin
                        if (!nx.repeating && (nx.elapsed >= cfg.hold_delay)) begin
                           nx.long_hold = 1'b1;
                           nx.repeating = 1'b1;
                        end
                        if (nx.repeating && (nx.elapsed >= cfg.repeat_period)) begin
                           nx.elapsed = 8'd0;
                           ev         = kped_pkg::EV_REPEAT;
                           done       = 1'b1;
                        end
                     end else begin
                        nx.repeating = 1'b0;
                     end
                     if (!done) begin
                        nx.prev_level = k;
                        ev = nx.repeating ? kped_pkg::EV_HOLDING : kped_pkg::EV_NONE;
                     end
                  end
               end
               default: ev = kped_pkg::EV_NONE;
            endcase
         end
         default: ev = kped_pkg::EV_NONE;
      endcase
   end

   assign state_in = step ? nx : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   `KPED_ASSERT_SAME(a_force_no_event, step && (cmd != kped_pkg::CMD_SAMPLE), ev == kped_pkg::EV_NONE)

endmodule

@@ src/key_press_event_detector_core.sv @@
// Key press event detector: one button sample per transfer, one event code per transfer.
// A sample is taken into an input register, the detector logic runs on it and its event
// lands in a result register; a new sample is taken every cycle unless the result side
// stalls. The only feedback loop is the registered update of the detector state (level,
// repeat flags, decisecond counter). The mode register selects edge press, double press,
// press with auto-repeat, or release press with long-hold repeat and a holding code.
// Configuration must be written through the apb-style port while no transfer is in
// flight; the block does not enforce this. No clearing pass after reset.
// depends on kped_pkg, kped_csr, kped_detect and key_press_event_detector_core_assert.svh
`include "key_press_event_detector_core_assert.svh"

module key_press_event_detector_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_cmd,
   input  logic                            req_key_level,
   input  logic                            req_tick,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_event_res,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [kped_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [kped_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [kped_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   kped_pkg::cfg_type   cfg;
   kped_pkg::state_type st;

   logic       in_vld_ff,  in_vld_in;
   logic [1:0] in_cmd_ff,  in_cmd_in;
   logic       in_key_ff,  in_key_in;
   logic       in_tick_ff, in_tick_in;
   logic       out_vld_ff, out_vld_in;
   logic [1:0] out_ev_ff,  out_ev_in;
   logic [1:0] ev;
   logic       accept;
   logic       advance;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid     = out_vld_ff;
   assign rsp_event_res = out_ev_ff;

   kped_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   kped_detect u_detect (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .cmd       (in_cmd_ff),
      .key_level (in_key_ff),
      .tick      (in_tick_ff),
      .cfg       (cfg),
      .event_res (ev),
      .state     (st)
   );

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_cmd_in  = in_cmd_ff;
      in_key_in  = in_key_ff;
      in_tick_in = in_tick_ff;
      if (accept) begin
         in_vld_in  = 1'b1;
         in_cmd_in  = req_cmd;
         in_key_in  = req_key_level;
         in_tick_in = req_tick;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      out_ev_in  = out_ev_ff;
      if (advance) begin
         out_vld_in = 1'b1;
         out_ev_in  = ev;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_cmd_ff  <= in_cmd_in;
      in_key_ff  <= in_key_in;
      in_tick_ff <= in_tick_in;
      out_ev_ff  <= out_ev_in;
   end

   `KPED_ASSERT_NEXT(a_advance_fills_result, advance, out_vld_ff)
   `KPED_ASSERT_SAME(a_holding_needs_repeat, out_vld_ff && (out_ev_ff == kped_pkg::EV_HOLDING), st.repeating)
   `KPED_ASSERT_SAME(a_repeat_restarts_count, out_vld_ff && (out_ev_ff == kped_pkg::EV_REPEAT), st.elapsed == 8'd0)

endmodule

@@ sim/tb_top.sv @@
// testbench for key_press_event_detector_core: directed and random button samples,
// apb register writes with read-back, and a transfer-level predictor of the event codes
// depends on kped_pkg and the key_press_event_detector_core rtl
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int DATA_W = kped_pkg::CSR_DATA_W;
   localparam int DRAIN_CYCLES = 4;
   localparam int LONG_STALL_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [1:0] cmd;
      logic       key_level;
      logic       tick;
   } key_sample_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [1:0]                      req_cmd = kped_pkg::CMD_SAMPLE;
   logic                            req_key_level = 1'b0;
   logic                            req_tick = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [1:0]                      rsp_event_res;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [kped_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0]               pwdata = '0;
   logic [DATA_W-1:0]               prdata;
   logic                            pready;

   key_sample_type      sample_queue[$];
   key_sample_type      drive_sample;
   logic [1:0]          expected_events[$];
   logic [1:0]          want_event;
   kped_pkg::cfg_type   det_cfg;
   kped_pkg::state_type det_state;
   int                  sender_idle_pct = 7;
   int                  receiver_idle_pct = 55;
   int                  mismatch_count = 0;
   int                  events_seen = 0;
   int                  stall_left = 0;
   int                  quiet_cycles = 0;

   key_press_event_detector_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_key_level (req_key_level),
      .req_tick      (req_tick),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #5 clock = ~clock;

   function automatic logic [1:0] detect_event(logic [1:0] cmd, logic key, logic tick);
      logic [1:0] ev;
      logic       hit;
      logic       in_window;
      ev = kped_pkg::EV_NONE;
      if (tick && det_state.elapsed != kped_pkg::ELAPSED_MAX)
         det_state.elapsed = det_state.elapsed + 8'd1;
      case (cmd)
         kped_pkg::CMD_FORCE_HIGH: det_state.prev_level = 1'b1;
         kped_pkg::CMD_FORCE_LOW: det_state.prev_level = 1'b0;
         kped_pkg::CMD_SAMPLE: begin
            case (det_cfg.mode)
               kped_pkg::MODE_EDGE: begin
                  if (!det_state.prev_level && key) ev = kped_pkg::EV_PRESS;
                  det_state.prev_level = key;
               end
               kped_pkg::MODE_DOUBLE: begin
                  hit = !det_state.prev_level && key;
                  det_state.prev_level = key;
                  if (!det_state.first_press_seen && hit) begin
                     det_state.first_press_seen = 1'b1;
                     det_state.elapsed = '0;
                  end else begin
                     in_window = det_state.elapsed <= det_cfg.double_window;
                     if (det_state.first_press_seen && in_window && hit) begin
                        det_state.first_press_seen = 1'b0;
                        ev = kped_pkg::EV_PRESS;
                     end else if (!in_window) begin
                        det_state.first_press_seen = 1'b0;
                     end
                  end
               end
               kped_pkg::MODE_REPEAT: begin
                  if (!det_state.prev_level && key) begin
                     det_state.prev_level = 1'b1;
                     det_state.elapsed = '0;
                     ev = kped_pkg::EV_PRESS;
                  end else begin
                     det_state.prev_level = key;
                     if (key) begin
                        if (!det_state.repeating
                            && det_state.elapsed >= det_cfg.hold_delay) begin
                           det_state.repeating = 1'b1;
                           det_state.elapsed = '0;
                        end
                        if (det_state.repeating
                            && det_state.elapsed >= det_cfg.repeat_period) begin
                           det_state.elapsed = '0;
                           ev = kped_pkg::EV_REPEAT;
                        end
                     end else begin
                        det_state.repeating = 1'b0;
                     end
                  end
               end
               kped_pkg::MODE_RELEASE: begin
                  if (det_state.long_hold && det_state.prev_level && !key) begin
                     det_state.long_hold = 1'b0;
                     det_state.prev_level = 1'b0;
                  end
                  if (!det_state.prev_level && key) det_state.elapsed = '0;
                  if (!det_state.long_hold && det_state.prev_level && !key) begin
                     det_state.prev_level = 1'b0;
                     det_state.elapsed = '0;
                     ev = kped_pkg::EV_PRESS;
                  end else begin
                     if (det_state.prev_level && key) begin
                        if (!det_state.repeating
                            && det_state.elapsed >= det_cfg.hold_delay) begin
                           det_state.long_hold = 1'b1;
                           det_state.repeating = 1'b1;
                        end
                        if (det_state.repeating
                            && det_state.elapsed >= det_cfg.repeat_period) begin
                           det_state.elapsed = '0;
                           ev = kped_pkg::EV_REPEAT;
                        end
                     end else begin
                        det_state.repeating = 1'b0;
                     end
                     if (ev != kped_pkg::EV_REPEAT) begin
                        det_state.prev_level = key;
                        if (det_state.repeating) ev = kped_pkg::EV_HOLDING;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      return ev;
   endfunction

   // input side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_events.push_back(detect_event(req_cmd, req_key_level, req_tick));
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               drive_sample = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_cmd <= drive_sample.cmd;
               req_key_level <= drive_sample.key_level;
               req_tick <= drive_sample.tick;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side, with a long hold-off at each of two fixed transfer counts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            events_seen = events_seen + 1;
            if (expected_events.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected event %0d with nothing pending", rsp_event_res);
               mismatch_count = mismatch_count + 1;
            end else begin
               want_event = expected_events.pop_front();
               if (rsp_event_res !== want_event) begin
                  if (mismatch_count < 10)
                     $display("event mismatch at transfer %0d: expected %0d, got %0d",
                              events_seen, want_event, rsp_event_res);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (rsp_valid && !rsp_stall && (events_seen == 60 || events_seen == 320)) begin
            rsp_stall <= 1'b1;
            stall_left <= LONG_STALL_CYCLES;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("key_press_event_detector_core regression: fail");
         $finish;
      end
   end

   function automatic void queue_sample(logic [1:0] cmd, logic key, logic tick);
      key_sample_type s;
      s.cmd = cmd;
      s.key_level = key;
      s.tick = tick;
      sample_queue.push_back(s);
   endfunction

   // press and release runs of random length, with glitches and some commands mixed in
   function automatic void queue_key_activity(int count, int tick_pct);
      logic       level;
      int         run_left;
      int         roll;
      logic [1:0] cmd;
      logic       key;
      level = 1'($urandom_range(1));
      run_left = 0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            level = ~level;
            run_left = $urandom_range(1, 14);
         end
         run_left--;
         roll = $urandom_range(99);
         if (roll < 4) cmd = kped_pkg::CMD_FORCE_HIGH;
         else if (roll < 8) cmd = kped_pkg::CMD_FORCE_LOW;
         else if (roll < 10) cmd = CMD_UNUSED;
         else cmd = kped_pkg::CMD_SAMPLE;
         key = ($urandom_range(99) < 6) ? ~level : level;
         queue_sample(cmd, key, $urandom_range(99) < tick_pct);
      end
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_events.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] reg_idx, logic [7:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_idx, 2'b00};
      pwdata <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DATA_W'(value)) begin
         if (mismatch_count < 10)
            $display("register %0d read-back: expected %0d, got %0d", reg_idx, value, prdata);
         mismatch_count = mismatch_count + 1;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      case (reg_idx)
         kped_pkg::REG_MODE: det_cfg.mode = value[1:0];
         kped_pkg::REG_HOLD_DELAY: det_cfg.hold_delay = value;
         kped_pkg::REG_REPEAT_PERIOD: det_cfg.repeat_period = value;
         kped_pkg::REG_DOUBLE_WINDOW: det_cfg.double_window = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   initial begin
      int         tick_pct;
      logic [7:0] hold_v;
      logic [7:0] period_v;
      logic [7:0] window_v;
      det_cfg = '{mode: kped_pkg::MODE_RST, hold_delay: kped_pkg::HOLD_DELAY_RST,
                  repeat_period: kped_pkg::REPEAT_PERIOD_RST,
                  double_window: kped_pkg::DOUBLE_WINDOW_RST};
      det_state = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // edge press, forced levels and the unused command
      write_register(kped_pkg::REG_MODE, {6'd0, kped_pkg::MODE_EDGE});
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_FORCE_LOW, 1'b1, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_FORCE_HIGH, 1'b0, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(CMD_UNUSED, 1'b0, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b0);
      wait_drained();

      // zero hold and period: repeat on every held sample
      write_register(kped_pkg::REG_MODE, {6'd0, kped_pkg::MODE_REPEAT});
      write_register(kped_pkg::REG_HOLD_DELAY, 8'd0);
      write_register(kped_pkg::REG_REPEAT_PERIOD, 8'd0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b1);
      wait_drained();

      // double press: timeout with a zero window, then a press pair in window
      write_register(kped_pkg::REG_MODE, {6'd0, kped_pkg::MODE_DOUBLE});
      write_register(kped_pkg::REG_DOUBLE_WINDOW, 8'd0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      wait_drained();

      // release press, then long hold with zero hold delay
      write_register(kped_pkg::REG_MODE, {6'd0, kped_pkg::MODE_RELEASE});
      write_register(kped_pkg::REG_HOLD_DELAY, 8'd255);
      write_register(kped_pkg::REG_REPEAT_PERIOD, 8'd255);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b1);
      wait_drained();
      write_register(kped_pkg::REG_HOLD_DELAY, 8'd0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b0);
      wait_drained();

      // counter saturation, then hold and period at their maximum
      write_register(kped_pkg::REG_HOLD_DELAY, 8'd255);
      for (int n = 0; n < 260; n++)
         queue_sample(kped_pkg::CMD_FORCE_HIGH, 1'($urandom_range(1)), 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b1);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b1, 1'b0);
      queue_sample(kped_pkg::CMD_SAMPLE, 1'b0, 1'b0);
      wait_drained();

      for (int phase = 0; phase < 9; phase++) begin
         if (phase == 3) begin
            sender_idle_pct = 55;
            receiver_idle_pct = 7;
         end else if (phase == 6) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         if (phase == 2) begin
            hold_v = 8'd0;
            period_v = 8'd0;
            window_v = 8'd0;
         end else if (phase == 5) begin
            hold_v = 8'd255;
            period_v = 8'd255;
            window_v = 8'd255;
         end else begin
            hold_v = 8'($urandom_range(8));
            period_v = 8'($urandom_range(8));
            window_v = 8'($urandom_range(8));
         end
         tick_pct = $urandom_range(20, 80);
         write_register(kped_pkg::REG_MODE, 8'((phase + 1) % 4));
         write_register(kped_pkg::REG_HOLD_DELAY, hold_v);
         write_register(kped_pkg::REG_REPEAT_PERIOD, period_v);
         write_register(kped_pkg::REG_DOUBLE_WINDOW, window_v);
         queue_key_activity(9, tick_pct);
         wait_drained();
         queue_key_activity(9, tick_pct);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("key_press_event_detector_core regression: pass");
      end else begin
         $display("key_press_event_detector_core regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/kped_pkg.sv
src/kped_csr.sv
src/kped_detect.sv
src/key_press_event_detector_core.sv
sim/tb_top.sv
